@@ hdl/mrs_pkg.sv @@
// ---------------------------------------------------------------------------
// mrs_pkg: shared types and constants of the motor run supervisor
// Register indexes, state codes, config, item and state structs and reset values.
// ---------------------------------------------------------------------------
package mrs_pkg;

    // Commutation geometry and tick length
    localparam int unsigned SECTORS  = 6;
    localparam int unsigned SECTOR_W = 3;
    localparam logic [15:0] TICK_US  = 16'd1000;

    // Run state codes
    localparam logic [1:0] ST_STOP  = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // Fault codes
    localparam logic [1:0] FLT_NONE   = 2'd0;
    localparam logic [1:0] FLT_DUTY   = 2'd1;
    localparam logic [1:0] FLT_WINDOW = 2'd2;
    localparam logic [1:0] FLT_BRIDGE = 2'd3;

    // Host request codes
    localparam logic [1:0] REQ_RUN  = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;

    // Drive modes
    localparam logic [1:0] DRIVE_STEP = 2'd0;

    // Register indexes
    localparam logic [1:0] REG_ARM_KEY  = 2'd0;
    localparam logic [1:0] REG_DUTY_CEIL = 2'd1;
    localparam logic [1:0] REG_STEP_PER = 2'd2;
    localparam logic [1:0] REG_DRIVE    = 2'd3;

    // Register reset values
    localparam logic [31:0] ARM_KEY_RST   = 32'hA5A5_A5A5;
    localparam logic [9:0]  DUTY_CEIL_RST = 10'd1000;
    localparam logic [15:0] STEP_PER_RST  = 16'd10000;
    localparam logic [1:0]  DRIVE_RST     = DRIVE_STEP;

    typedef struct packed {
        logic [31:0] arm_key_value;
        logic [9:0]  duty_ceiling;
        logic [15:0] step_period_us;
        logic [1:0]  drive_mode;
    } cfg_t;

    typedef struct packed {
        logic [31:0] key_word;
        logic [1:0]  request_code;
        logic [31:0] sequence_req;
        logic [15:0] duty_request;
        logic [31:0] run_window_ms;
        logic        bridge_on_feedback;
    } item_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic [1:0]          fault;
        logic [31:0]         run_count;
        logic [31:0]         run_limit;
        logic [SECTOR_W-1:0] sector;
        logic [15:0]         step_timer;
        logic [31:0]         active_tag;
        logic [31:0]         ack;
        logic                capture_armed;
        logic [31:0]         step_total;
        logic [9:0]          duty;
        logic [31:0]         tick_total;
        logic                enable;
    } state_t;

endpackage

@@ hdl/motor_run_supervisor.sv @@
// ---------------------------------------------------------------------------
// motor_run_supervisor: motor bridge run supervisor, one item per 1 ms tick
// Input register, combinational tick update, status held in the state register.
// ---------------------------------------------------------------------------
// Each transfer on the input channel is one 1 ms tick and produces exactly one
// status transfer. The block sustains one tick per clock cycle while out_ready
// is high: a tick is captured in the input register, and then the combinational
// next-state logic updates the supervisor state, which is itself the status
// presented on the output ports. While the status waits for out_ready, one
// more tick can be held in the input register. Configuration writes are
// accepted at any time, and should be made only while no tick is in flight.
module motor_run_supervisor
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Tick input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] key_word,
    input  logic [1:0]  request_code,
    input  logic [31:0] sequence_req,
    input  logic [15:0] duty_request,
    input  logic [31:0] run_window_ms,
    input  logic        bridge_on_feedback,
    // Status output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  run_state,
    output logic [1:0]  fault_code,
    output logic [2:0]  sector_now,
    output logic [31:0] elapsed_ms,
    output logic [9:0]  duty_applied,
    output logic [31:0] step_count,
    output logic        bridge_enable,
    output logic [31:0] acked_sequence,
    output logic [31:0] uptime,
    output logic        capture_pulse,
    output logic [31:0] capture_tag
);
    import mrs_pkg::*;

    cfg_t   cfg;
    item_t  item_reg;
    logic   item_valid_reg;
    logic   item_valid_next;
    state_t state_reg;
    state_t state_next;
    logic   pulse_reg;
    logic   pulse_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   advance;

    // Configuration registers
    mrs_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Tick update logic
    mrs_tick_logic u_tick
    (
        .cfg   (cfg),
        .item  (item_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .pulse (pulse_next)
    );

    // Handshake: a tick moves on when the status slot is free or being taken
    assign advance         = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready        = !item_valid_reg || advance;
    assign item_valid_next = (in_valid && in_ready) ? 1'b1 :
                             (advance ? 1'b0 : item_valid_reg);
    assign out_valid_next  = advance ? 1'b1 :
                             (out_ready ? 1'b0 : out_valid_reg);

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.key_word           <= key_word;
            item_reg.request_code       <= request_code;
            item_reg.sequence_req       <= sequence_req;
            item_reg.duty_request       <= duty_request;
            item_reg.run_window_ms      <= run_window_ms;
            item_reg.bridge_on_feedback <= bridge_on_feedback;
        end
    end

    // Control and supervisor state; all-zero state is stopped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pulse_reg      <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
                pulse_reg <= pulse_next;
            end
        end
    end

    // Status ports
    assign out_valid      = out_valid_reg;
    assign run_state      = state_reg.mode;
    assign fault_code     = state_reg.fault;
    assign sector_now     = state_reg.sector;
    assign elapsed_ms     = state_reg.run_count;
    assign duty_applied   = state_reg.duty;
    assign step_count     = state_reg.step_total;
    assign bridge_enable  = state_reg.enable;
    assign acked_sequence = state_reg.ack;
    assign uptime         = state_reg.tick_total;
    assign capture_pulse  = pulse_reg;
    assign capture_tag    = state_reg.active_tag;

endmodule

@@ hdl/mrs_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// mrs_cfg_regs: configuration register file
// Holds key, duty ceiling, step period and drive mode; one write per transfer.
// ---------------------------------------------------------------------------
module mrs_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output mrs_pkg::cfg_t cfg
);
    import mrs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes never stall
    assign cfg_ready = 1'b1;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ARM_KEY:   cfg_next.arm_key_value  = cfg_data;
                REG_DUTY_CEIL: cfg_next.duty_ceiling   = cfg_data[9:0];
                REG_STEP_PER:  cfg_next.step_period_us = cfg_data[15:0];
                REG_DRIVE:     cfg_next.drive_mode     = cfg_data[1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_key_value  <= ARM_KEY_RST;
            cfg_reg.duty_ceiling   <= DUTY_CEIL_RST;
            cfg_reg.step_period_us <= STEP_PER_RST;
            cfg_reg.drive_mode     <= DRIVE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/mrs_tick_logic.sv @@
// ---------------------------------------------------------------------------
// mrs_tick_logic: next-state logic for one 1 ms tick
// Start checks, run bookkeeping, sector stepping and stop/fault handling.
// ---------------------------------------------------------------------------
module mrs_tick_logic
(
    input  mrs_pkg::cfg_t   cfg,
    input  mrs_pkg::item_t  item,
    input  mrs_pkg::state_t cur,
    output mrs_pkg::state_t nxt,
    output logic            pulse
);
    import mrs_pkg::*;

    logic        armed;
    logic        halt;
    logic [1:0]  halt_code;
    logic [15:0] period;
    logic [16:0] acc;

    // Step period floors at one tick
    assign period = (cfg.step_period_us < TICK_US) ? TICK_US : cfg.step_period_us;
    assign armed  = (item.key_word == cfg.arm_key_value);

    always_comb
    begin
        nxt        = cur;
        pulse      = 1'b0;
        halt       = 1'b0;
        halt_code  = FLT_NONE;
        acc        = {1'b0, cur.step_timer} + {1'b0, TICK_US};

        nxt.tick_total = cur.tick_total + 32'd1;

        if (cur.mode != ST_RUN)
        begin
            // Start request from stopped or fault
            if (armed && item.request_code == REQ_RUN &&
                item.sequence_req != cur.ack && item.sequence_req != 32'd0)
            begin
                nxt.active_tag = item.sequence_req;
                if (item.duty_request > {6'd0, cfg.duty_ceiling})
                begin
                    halt      = 1'b1;
                    halt_code = FLT_DUTY;
                end
                else if (item.run_window_ms == 32'd0)
                begin
                    halt      = 1'b1;
                    halt_code = FLT_WINDOW;
                end
                else
                begin
                    nxt.run_limit     = item.run_window_ms;
                    nxt.run_count     = 32'd0;
                    nxt.sector        = '0;
                    nxt.step_timer    = 16'd0;
                    nxt.duty          = item.duty_request[9:0];
                    nxt.fault         = FLT_NONE;
                    nxt.step_total    = 32'd0;
                    nxt.enable        = 1'b1;
                    nxt.mode          = ST_RUN;
                    nxt.capture_armed = 1'b1;
                end
            end
        end
        else if (!armed || item.request_code == REQ_STOP)
        begin
            halt = 1'b1;
        end
        else if (!item.bridge_on_feedback)
        begin
            halt      = 1'b1;
            halt_code = FLT_BRIDGE;
        end
        else
        begin
            nxt.run_count = cur.run_count + 32'd1;

            // At most one sector step per tick, remainder carries
            if (cfg.drive_mode == DRIVE_STEP)
            begin
                if (acc >= {1'b0, period})
                begin
                    acc            = acc - {1'b0, period};
                    nxt.sector     = (cur.sector == SECTOR_W'(SECTORS - 1)) ?
                                     '0 : cur.sector + SECTOR_W'(1);
                    nxt.step_total = cur.step_total + 32'd1;
                end
                nxt.step_timer = acc[15:0];
            end

            // Capture pulse on first running tick
            if (cur.capture_armed)
            begin
                nxt.capture_armed = 1'b0;
                pulse             = 1'b1;
            end

            if (nxt.run_count >= cur.run_limit)
            begin
                halt = 1'b1;
            end
        end

        // Stop or fault: drop the bridge and acknowledge
        if (halt)
        begin
            nxt.enable        = 1'b0;
            nxt.duty          = 10'd0;
            nxt.capture_armed = 1'b0;
            nxt.run_count     = 32'd0;
            nxt.run_limit     = 32'd0;
            nxt.fault         = halt_code;
            nxt.mode          = (halt_code == FLT_NONE) ? ST_STOP : ST_FAULT;
            nxt.ack           = nxt.active_tag;
        end
    end

endmodule

@@ hdl/mrs_checker.sv @@
// ---------------------------------------------------------------------------
// mrs_checker: port-level checks of the motor run supervisor
// Status consistency and output hold under back-pressure; bound to the top.
// ---------------------------------------------------------------------------
module mrs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  run_state,
    input logic [31:0] elapsed_ms,
    input logic [9:0]  duty_applied,
    input logic        bridge_enable,
    input logic [31:0] uptime,
    input logic        capture_pulse
);
    import mrs_pkg::*;

    // Stalled status transfer holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(uptime))
        else $error("status changed while stalled");

    // Bridge is only enabled while running
    a_enable_run: assert property (@(posedge clk) disable iff (!rst_n)
        bridge_enable |-> run_state == ST_RUN)
        else $error("bridge enabled outside run");

    // Outside a run nothing is driven and the run timer is clear
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        run_state != ST_RUN |-> elapsed_ms == 32'd0 && duty_applied == 10'd0
                               && !bridge_enable)
        else $error("run outputs not cleared");

    // Capture pulse only on the first running tick
    a_capture_first: assert property (@(posedge clk) disable iff (!rst_n)
        capture_pulse |-> elapsed_ms == 32'd1 || elapsed_ms == 32'd0)
        else $error("capture pulse late in run");

endmodule

bind motor_run_supervisor mrs_checker u_mrs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .run_state     (run_state),
    .elapsed_ms    (elapsed_ms),
    .duty_applied  (duty_applied),
    .bridge_enable (bridge_enable),
    .uptime        (uptime),
    .capture_pulse (capture_pulse)
);
